[hw/rtl/hcps_pkg.sv]
// Shared constants, tables and types of the hollow cylinder point sampler.
package hcps_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int SQRT_BITS     = 25;
    localparam int RAD_W         = 50;
    localparam int ANG_W         = 34;
    localparam int PROD_W        = ANG_W + 25;
    localparam int ADDR_W        = 6;

    localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [PROD_W-1:0] COORD_MAX  = 59'sd16777215;
    localparam logic signed [PROD_W-1:0] COORD_MIN  = -59'sd16777215;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 59'sd536870912;

    localparam logic [1:0] REGION_TOP    = 2'd0;
    localparam logic [1:0] REGION_SHELL  = 2'd1;
    localparam logic [1:0] REGION_BOTTOM = 2'd2;

    localparam logic [2:0] REG_OUTER_RADIUS    = 3'd0;
    localparam logic [2:0] REG_INNER_RADIUS_SQ = 3'd1;
    localparam logic [2:0] REG_RADIUS_SQ_SPAN  = 3'd2;
    localparam logic [2:0] REG_INNER_HEIGHT    = 3'd3;
    localparam logic [2:0] REG_CAP_HEIGHT      = 3'd4;
    localparam logic [2:0] REG_TOP_PROB        = 3'd5;
    localparam logic [2:0] REG_LATERAL_PROB    = 3'd6;

    // atan(2^-i) in 2^-32 turns
    localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [1:0]              region;
        logic [1:0]              quad;
        logic signed [ANG_W-1:0] ang;
        logic [15:0]             u_radius;
        logic [47:0]             span_prod;
        logic [23:0]             cap_prod;
        logic [23:0]             shell_prod;
    } front_t;

    typedef struct packed {
        logic [1:0]              region;
        logic [1:0]              quad;
        logic signed [25:0]      pos_z;
        logic signed [ANG_W-1:0] cx;
        logic signed [ANG_W-1:0] cy;
        logic signed [ANG_W-1:0] ang;
        logic [RAD_W-1:0]        rem;
        logic [SQRT_BITS-1:0]    root;
    } stage_t;

    typedef struct packed {
        logic [1:0]              region;
        logic signed [25:0]      pos_z;
        logic [23:0]             radius;
        logic signed [ANG_W-1:0] cos_v;
        logic signed [ANG_W-1:0] sin_v;
    } scale_t;

    typedef struct packed {
        logic [1:0]               region;
        logic signed [25:0]       pos_z;
        logic signed [PROD_W-1:0] prod_x;
        logic signed [PROD_W-1:0] prod_y;
    } prod_t;

endpackage

[hw/rtl/hcps_if.sv]
// Request and result channel interfaces of the point sampler.
interface hcps_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] u_angle;
    logic [15:0] u_region;
    logic [15:0] u_radius;
    logic [15:0] u_height;

    modport source (output valid, u_angle, u_region, u_radius, u_height, input ready);
    modport sink   (input valid, u_angle, u_region, u_radius, u_height, output ready);
endinterface

interface hcps_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [24:0] pos_x;
    logic signed [24:0] pos_y;
    logic signed [25:0] pos_z;
    logic [1:0]         region;

    modport source (output valid, pos_x, pos_y, pos_z, region, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, region, output ready);
endinterface

[hw/rtl/hollow_cylinder_point_sampler_core.sv]
// Hollow cylinder point sampler: top level with the full sampling pipeline.
// Throughput: one request per cycle; the pipeline is 16 CORDIC steps run in
// parallel with a 25-step bit-per-stage square root, plus front and scaling stages.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n, async, active low) clears valid bits and loads register defaults.
module hollow_cylinder_point_sampler_core
    import hcps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    hcps_req_if.sink          req,
    hcps_rsp_if.source        rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    // ------------------------------------------------------------------
    // Configuration registers (APB, 8-byte stride)
    // ------------------------------------------------------------------
    logic [23:0] outer_radius_reg;
    logic [47:0] inner_radius_sq_reg;
    logic [47:0] radius_sq_span_reg;
    logic [23:0] inner_height_reg;
    logic [23:0] cap_height_reg;
    logic [16:0] top_prob_reg;
    logic [16:0] lateral_prob_reg;
    logic [2:0]  reg_index;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_radius_reg    <= '0;
            inner_radius_sq_reg <= '0;
            radius_sq_span_reg  <= '0;
            inner_height_reg    <= '0;
            cap_height_reg      <= '0;
            top_prob_reg        <= '0;
            lateral_prob_reg    <= 17'h10000;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_OUTER_RADIUS:    outer_radius_reg    <= pwdata[23:0];
                REG_INNER_RADIUS_SQ: inner_radius_sq_reg <= pwdata[47:0];
                REG_RADIUS_SQ_SPAN:  radius_sq_span_reg  <= pwdata[47:0];
                REG_INNER_HEIGHT:    inner_height_reg    <= pwdata[23:0];
                REG_CAP_HEIGHT:      cap_height_reg      <= pwdata[23:0];
                REG_TOP_PROB:        top_prob_reg        <= pwdata[16:0];
                REG_LATERAL_PROB:    lateral_prob_reg    <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_OUTER_RADIUS:    prdata = {40'd0, outer_radius_reg};
            REG_INNER_RADIUS_SQ: prdata = {16'd0, inner_radius_sq_reg};
            REG_RADIUS_SQ_SPAN:  prdata = {16'd0, radius_sq_span_reg};
            REG_INNER_HEIGHT:    prdata = {40'd0, inner_height_reg};
            REG_CAP_HEIGHT:      prdata = {40'd0, cap_height_reg};
            REG_TOP_PROB:        prdata = {47'd0, top_prob_reg};
            REG_LATERAL_PROB:    prdata = {47'd0, lateral_prob_reg};
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipe advances unless the result is stalled
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic advance;

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = advance;

    // ------------------------------------------------------------------
    // Front stage: region pick, quadrant fold, the three input products
    // ------------------------------------------------------------------
    front_t      front_reg;
    front_t      front_next;
    logic        front_valid_reg;
    logic [15:0] quad_off;
    logic [15:0] resid;
    logic [63:0] span_full;
    logic [39:0] cap_full;
    logic [39:0] shell_full;

    always_comb
    begin
        front_next.quad = 2'((req.u_angle + 16'h2000) >> 14);
        quad_off        = {front_next.quad, 14'd0};
        // residual wraps into [-8192, 8191] as a 16-bit two's complement value
        resid           = req.u_angle - quad_off;
        front_next.ang  = ANG_W'($signed({resid, 16'd0}));
        if ({1'b0, req.u_region} < top_prob_reg)
            front_next.region = REGION_TOP;
        else if ({1'b0, req.u_region} < lateral_prob_reg)
            front_next.region = REGION_SHELL;
        else
            front_next.region = REGION_BOTTOM;
        span_full             = radius_sq_span_reg * {48'd0, req.u_radius};
        cap_full              = cap_height_reg * {24'd0, req.u_height};
        shell_full            = inner_height_reg * {24'd0, req.u_height};
        front_next.span_prod  = span_full[63:16];
        front_next.cap_prod   = cap_full[39:16];
        front_next.shell_prod = shell_full[39:16];
        front_next.u_radius   = req.u_radius;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else if (advance)
            front_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            front_reg <= front_next;
    end

    // ------------------------------------------------------------------
    // Seed of the CORDIC / square root chain, plus z placement
    // ------------------------------------------------------------------
    stage_t             stage_reg   [SQRT_BITS+1];
    stage_t             stage_next  [SQRT_BITS+1];
    logic               stage_valid_reg [SQRT_BITS+1];
    logic signed [25:0] half_h;

    always_comb
    begin
        half_h                = 26'($signed({3'd0, inner_height_reg[23:1]}));
        stage_next[0].region  = front_reg.region;
        stage_next[0].quad    = front_reg.quad;
        stage_next[0].cx      = CORDIC_GAIN;
        stage_next[0].cy      = '0;
        stage_next[0].ang     = front_reg.ang;
        stage_next[0].root    = '0;
        if (front_reg.region == REGION_SHELL)
        begin
            stage_next[0].rem   = RAD_W'(inner_radius_sq_reg) + RAD_W'(front_reg.span_prod);
            stage_next[0].pos_z = 26'($signed({2'd0, front_reg.shell_prod})) - half_h;
        end
        else
        begin
            stage_next[0].rem = RAD_W'({front_reg.u_radius, 16'd0});
            if (front_reg.region == REGION_TOP)
                stage_next[0].pos_z = half_h + 26'($signed({2'd0, front_reg.cap_prod}));
            else
                stage_next[0].pos_z = -half_h - 26'($signed({2'd0, front_reg.cap_prod}));
        end
    end

    // ------------------------------------------------------------------
    // Chain: stage k resolves root bit SQRT_BITS-1-k and, for the first
    // CORDIC_STAGES stages, runs CORDIC micro-rotation k
    // ------------------------------------------------------------------
    for (genvar k = 0; k < SQRT_BITS; k++)
    begin : g_chain
        localparam int BIT = SQRT_BITS - 1 - k;
        logic [RAD_W-1:0]        delta;
        logic signed [ANG_W-1:0] cx_rot;
        logic signed [ANG_W-1:0] cy_rot;
        logic signed [ANG_W-1:0] ang_rot;

        if (k < CORDIC_STAGES && k < ATAN_ENTRIES)
        begin : g_cordic
            logic signed [ANG_W-1:0] dx;
            logic signed [ANG_W-1:0] dy;
            logic signed [ANG_W-1:0] atan_v;

            assign dx     = stage_reg[k].cy >>> k;
            assign dy     = stage_reg[k].cx >>> k;
            assign atan_v = $signed({2'b00, ATAN_TABLE[k]});

            always_comb
            begin
                if (!stage_reg[k].ang[ANG_W-1])
                begin
                    cx_rot  = stage_reg[k].cx - dx;
                    cy_rot  = stage_reg[k].cy + dy;
                    ang_rot = stage_reg[k].ang - atan_v;
                end
                else
                begin
                    cx_rot  = stage_reg[k].cx + dx;
                    cy_rot  = stage_reg[k].cy - dy;
                    ang_rot = stage_reg[k].ang + atan_v;
                end
            end
        end
        else
        begin : g_pass
            assign cx_rot  = stage_reg[k].cx;
            assign cy_rot  = stage_reg[k].cy;
            assign ang_rot = stage_reg[k].ang;
        end

        always_comb
        begin
            stage_next[k+1]     = stage_reg[k];
            stage_next[k+1].cx  = cx_rot;
            stage_next[k+1].cy  = cy_rot;
            stage_next[k+1].ang = ang_rot;
            delta = (RAD_W'(stage_reg[k].root) << (BIT + 1)) + (RAD_W'(1) << (2 * BIT));
            if (stage_reg[k].rem >= delta)
            begin
                stage_next[k+1].rem       = stage_reg[k].rem - delta;
                stage_next[k+1].root[BIT] = 1'b1;
            end
        end
    end

    for (genvar k = 0; k <= SQRT_BITS; k++)
    begin : g_stage_regs
        logic prev_valid;

        if (k == 0)
        begin : g_first
            assign prev_valid = front_valid_reg;
        end
        else
        begin : g_rest
            assign prev_valid = stage_valid_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                stage_valid_reg[k] <= 1'b0;
            else if (advance)
                stage_valid_reg[k] <= prev_valid;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
                stage_reg[k] <= stage_next[k];
        end
    end

    // ------------------------------------------------------------------
    // Radius select and quadrant unfold
    // ------------------------------------------------------------------
    scale_t      scale_reg;
    scale_t      scale_next;
    logic        scale_valid_reg;
    logic [39:0] cap_radius;
    stage_t      last;

    assign last = stage_reg[SQRT_BITS];

    always_comb
    begin
        scale_next.region = last.region;
        scale_next.pos_z  = last.pos_z;
        cap_radius        = outer_radius_reg * {24'd0, last.root[15:0]};
        if (last.region == REGION_SHELL)
            scale_next.radius = last.root[SQRT_BITS-1] ? 24'hFFFFFF : last.root[23:0];
        else
            scale_next.radius = cap_radius[39:16];
        unique case (last.quad)
            2'd0:
            begin
                scale_next.cos_v = last.cx;
                scale_next.sin_v = last.cy;
            end
            2'd1:
            begin
                scale_next.cos_v = -last.cy;
                scale_next.sin_v = last.cx;
            end
            2'd2:
            begin
                scale_next.cos_v = -last.cx;
                scale_next.sin_v = -last.cy;
            end
            default:
            begin
                scale_next.cos_v = last.cy;
                scale_next.sin_v = -last.cx;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_valid_reg <= 1'b0;
        else if (advance)
            scale_valid_reg <= stage_valid_reg[SQRT_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            scale_reg <= scale_next;
    end

    // ------------------------------------------------------------------
    // Radius times cosine / sine
    // ------------------------------------------------------------------
    prod_t              prod_reg;
    prod_t              prod_next;
    logic               prod_valid_reg;
    logic signed [24:0] radius_s;

    always_comb
    begin
        radius_s         = $signed({1'b0, scale_reg.radius});
        prod_next.region = scale_reg.region;
        prod_next.pos_z  = scale_reg.pos_z;
        prod_next.prod_x = PROD_W'(radius_s) * PROD_W'(scale_reg.cos_v);
        prod_next.prod_y = PROD_W'(radius_s) * PROD_W'(scale_reg.sin_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_valid_reg <= 1'b0;
        else if (advance)
            prod_valid_reg <= scale_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            prod_reg <= prod_next;
    end

    // ------------------------------------------------------------------
    // Round half up, saturate, result register
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] round_x;
    logic signed [PROD_W-1:0] round_y;
    logic signed [24:0]       pos_x_next;
    logic signed [24:0]       pos_y_next;
    logic signed [24:0]       pos_x_reg;
    logic signed [24:0]       pos_y_reg;
    logic signed [25:0]       pos_z_reg;
    logic [1:0]               region_reg;

    always_comb
    begin
        round_x = (prod_reg.prod_x + ROUND_HALF) >>> 30;
        round_y = (prod_reg.prod_y + ROUND_HALF) >>> 30;
        priority if (round_x > COORD_MAX)
            pos_x_next = COORD_MAX[24:0];
        else if (round_x < COORD_MIN)
            pos_x_next = COORD_MIN[24:0];
        else
            pos_x_next = round_x[24:0];
        priority if (round_y > COORD_MAX)
            pos_y_next = COORD_MAX[24:0];
        else if (round_y < COORD_MIN)
            pos_y_next = COORD_MIN[24:0];
        else
            pos_y_next = round_y[24:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= prod_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            pos_z_reg  <= prod_reg.pos_z;
            region_reg <= prod_reg.region;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.pos_x  = pos_x_reg;
    assign rsp.pos_y  = pos_y_reg;
    assign rsp.pos_z  = pos_z_reg;
    assign rsp.region = region_reg;

`ifndef SYNTHESIS
    // a stalled result must hold off new requests
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |-> !req.ready)
        else $error("request taken while result stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.region != 2'd3))
        else $error("bad region code");

    // saturation keeps coordinates symmetric
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.pos_x != 25'h1000000 && rsp.pos_y != 25'h1000000))
        else $error("coordinate past saturation limit");
`endif

endmodule
